// ----- sv/csv_ft_pkg.sv -----
// Shared types and constants of the CSV field tokenizer.
package csv_ft_pkg;

  // parser states, one-hot
  typedef enum logic [5:0] {
    ST_START        = 6'b000001,
    ST_QUOTED       = 6'b000010,
    ST_MAYBE_END    = 6'b000100,
    ST_AFTER_QUOTE  = 6'b001000,
    ST_MAYBE_NORMAL = 6'b010000,
    ST_NORMAL       = 6'b100000
  } parse_state_t;

  typedef enum logic [1:0] {
    EV_APPEND  = 2'd0,
    EV_DISCARD = 2'd1,
    EV_DONE    = 2'd2
  } ev_kind_t;

  // configuration register indexes
  localparam logic [3:0] CFG_SEPARATOR = 4'd0;
  localparam logic [3:0] CFG_ROW_LIMIT = 4'd1;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BSL   = 8'd92;
  localparam logic [7:0] CH_N     = 8'd110;
  localparam logic [7:0] CH_COMMA = 8'd44;

  // result queue depth, room for two results per request plus slack
  localparam int QDEPTH = 4;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  ch;
    logic [15:0] row;
    logic [7:0]  col;
    logic        last;
  } ev_t;

  // results of one request, n in 0..2
  typedef struct packed {
    logic [1:0] n;
    ev_t        ev0;
    ev_t        ev1;
  } res_t;

endpackage

// ----- sv/csv_field_tokenizer.sv -----
// Top level of the streaming CSV field tokenizer.
//
// One text byte per input request (in_tdata, in_tuser = restart). Each byte
// is registered, run through the combinational tokenizer step, and its zero,
// one or two result events go into a four-entry queue that feeds the output
// stream. A byte is taken every cycle while the queue has room for two
// results; the sustained rate is one byte per cycle, bounded by the output
// side at one event per cycle, so bytes that raise two events lower it.
// Events: append (char in tdata), discard field, field done; each carries the
// row and column it belongs to (saturating counters, ROW_BITS/COL_BITS wide,
// reported as 16 and 8 bits). The last event of a byte has out_tlast set.
// A CR is dropped unless it directly follows a dropped CR. Backslash-n in
// field text comes out as one newline. A nonzero row_limit stops all output
// once the row count passes it, until a byte with restart set. A final field
// without a terminating separator or newline never produces a done event.
// Configuration: index 0 separator (default comma), index 1 row limit
// (0 = none); write only while the block is idle.
module csv_field_tokenizer import csv_ft_pkg::*; #(
  parameter int ROW_BITS = 16,
  parameter int COL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_in
  input  logic                  in_tuser,   // [0] restart
  // result events
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [7:0] char_out, [23:8] row_index,
                                            // [31:24] column_index
  output logic [1:0]            out_tuser,  // [1:0] event_kind
  output logic                  out_tlast,  // last_of_item
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_char_r;
  logic       in_rst_r;

  // configuration registers
  logic [7:0]  sep_r;
  logic [15:0] lim_r;

  logic step_fire, q_space;
  res_t res;
  ev_t  q_ev;

  assign step_fire  = in_vld_r && q_space;
  assign in_tready  = !in_vld_r || step_fire;
  assign in_vld_nxt = (in_tvalid && in_tready) || (in_vld_r && !step_fire);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // payload holds while a request waits in the register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_rst_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= CH_COMMA;
      lim_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_SEPARATOR: sep_r <= cfg_data[7:0];
        CFG_ROW_LIMIT: lim_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  csv_ft_step #(
    .ROW_BITS (ROW_BITS),
    .COL_BITS (COL_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (step_fire),
    .char_in   (in_char_r),
    .restart   (in_rst_r),
    .sep_char  (sep_r),
    .row_limit (lim_r),
    .res       (res)
  );

  csv_ft_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .push_en   (step_fire),
    .space     (q_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ev    (q_ev)
  );

  assign out_tdata = {q_ev.col, q_ev.row, q_ev.ch};
  assign out_tuser = q_ev.kind;
  assign out_tlast = q_ev.last;

  // a byte that could not step stays in the register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !step_fire) |=> (in_vld_r && $stable(in_char_r)))
    else $error("stalled byte lost");

endmodule

// ----- sv/csv_ft_step.sv -----
// Tokenizer state registers and the per-byte step logic.
module csv_ft_step import csv_ft_pkg::*; #(
  parameter int ROW_BITS = 16,
  parameter int COL_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_in,
  input  logic       restart,
  input  logic [7:0] sep_char,
  input  logic [15:0] row_limit,
  output res_t       res
);

  localparam int RW = (ROW_BITS > 16) ? ROW_BITS : 16;
  localparam int CW = (COL_BITS > 8) ? COL_BITS : 8;

  typedef struct packed {
    logic [1:0] n;
    ev_kind_t   k0;
    logic [7:0] c0;
    ev_kind_t   k1;
    logic [7:0] c1;
  } emit_t;

  function automatic emit_t add_ev(emit_t e, ev_kind_t k, logic [7:0] c);
    emit_t o;
    o = e;
    if (e.n == 2'd0) begin
      o.k0 = k;
      o.c0 = c;
      o.n  = 2'd1;
    end else if (e.n == 2'd1) begin
      o.k1 = k;
      o.c1 = c;
      o.n  = 2'd2;
    end
    return o;
  endfunction

  parse_state_t        st_r, st_nxt, st_cur;
  logic [ROW_BITS-1:0] row_r, row_nxt, row_cur;
  logic [COL_BITS-1:0] col_r, col_nxt, col_cur;
  logic                cr_r, cr_nxt;
  logic                bsl_r, bsl_nxt;
  logic                lim_r, lim_nxt;

  logic  is_sep, is_end;
  logic  do_app, do_fin, do_disc, do_adv;
  emit_t em;
  logic [RW-1:0] row_ext;
  logic [CW-1:0] col_ext;

  always_comb begin
    st_cur  = restart ? ST_START : st_r;
    row_cur = restart ? '0 : row_r;
    col_cur = restart ? '0 : col_r;
    st_nxt  = st_cur;
    row_nxt = row_cur;
    col_nxt = col_cur;
    cr_nxt  = restart ? 1'b0 : cr_r;
    bsl_nxt = restart ? 1'b0 : bsl_r;
    lim_nxt = restart ? 1'b0 : lim_r;
    is_sep  = (char_in == sep_char);
    is_end  = is_sep || (char_in == CH_LF);
    do_app  = 1'b0;
    do_fin  = 1'b0;
    do_disc = 1'b0;
    do_adv  = 1'b0;
    em      = '{n: 2'd0, k0: EV_APPEND, c0: 8'd0, k1: EV_APPEND, c1: 8'd0};

    if (!lim_nxt) begin
      if (char_in == CH_CR && !cr_nxt) begin
        cr_nxt = 1'b1;
      end else begin
        cr_nxt = 1'b0;
        case (st_cur)
          ST_QUOTED: begin
            if (char_in == CH_QUOTE) begin
              do_app = 1'b1;
              st_nxt = ST_MAYBE_END;
            end else if (char_in == CH_LF) begin
              do_fin = 1'b1;
            end else begin
              do_app = 1'b1;
            end
          end
          ST_MAYBE_END: begin
            if (char_in == CH_QUOTE) begin
              do_app = 1'b1;
              st_nxt = ST_QUOTED;
            end else if (is_end) begin
              do_fin = 1'b1;
            end else begin
              st_nxt = ST_AFTER_QUOTE;
            end
          end
          ST_AFTER_QUOTE: begin
            do_fin = is_end;
          end
          ST_MAYBE_NORMAL, ST_NORMAL: begin
            // quote in a bare field: drop what we have, restart as quoted
            if (st_cur == ST_MAYBE_NORMAL && char_in == CH_QUOTE) begin
              do_disc = 1'b1;
              st_nxt  = ST_QUOTED;
            end
            do_fin = is_end;
            do_app = !is_end;
          end
          default: begin
            if (char_in == CH_QUOTE) begin
              do_app = 1'b1;
              st_nxt = ST_QUOTED;
            end else if (is_end) begin
              do_adv = 1'b1;
              st_nxt = ST_START;
            end else begin
              do_app = 1'b1;
              st_nxt = ST_MAYBE_NORMAL;
            end
          end
        endcase

        if (do_disc) begin
          bsl_nxt = 1'b0;
          em = add_ev(em, EV_DISCARD, 8'd0);
        end
        if (do_app) begin
          if (bsl_nxt) begin
            if (char_in == CH_N) begin
              em = add_ev(em, EV_APPEND, CH_LF);
              bsl_nxt = 1'b0;
            end else begin
              em = add_ev(em, EV_APPEND, CH_BSL);
              if (char_in != CH_BSL) begin
                em = add_ev(em, EV_APPEND, char_in);
                bsl_nxt = 1'b0;
              end
            end
          end else if (char_in == CH_BSL) begin
            bsl_nxt = 1'b1;
          end else begin
            em = add_ev(em, EV_APPEND, char_in);
          end
        end
        if (do_fin) begin
          if (bsl_nxt) begin
            em = add_ev(em, EV_APPEND, CH_BSL);
            bsl_nxt = 1'b0;
          end
          em = add_ev(em, EV_DONE, 8'd0);
          do_adv = 1'b1;
          st_nxt = ST_START;
        end
        if (do_adv) begin
          if (char_in == CH_LF) begin
            if (row_cur != '1) row_nxt = row_cur + 1'b1;
            col_nxt = '0;
          end else if (col_cur != '1) begin
            col_nxt = col_cur + 1'b1;
          end
        end
        if (row_limit != 16'd0 && RW'(row_nxt) > RW'(row_limit)) lim_nxt = 1'b1;
      end
    end
  end

  // all events of one byte carry the counts from before the advance
  always_comb begin
    row_ext       = RW'(row_cur);
    col_ext       = CW'(col_cur);
    res.n         = em.n;
    res.ev0.kind  = em.k0;
    res.ev0.ch    = em.c0;
    res.ev0.row   = row_ext[15:0];
    res.ev0.col   = col_ext[7:0];
    res.ev0.last  = (em.n == 2'd1);
    res.ev1.kind  = em.k1;
    res.ev1.ch    = em.c1;
    res.ev1.row   = row_ext[15:0];
    res.ev1.col   = col_ext[7:0];
    res.ev1.last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_START;
      row_r <= '0;
      col_r <= '0;
      cr_r  <= 1'b0;
      bsl_r <= 1'b0;
      lim_r <= 1'b0;
    end else if (fire) begin
      st_r  <= st_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      cr_r  <= cr_nxt;
      bsl_r <= bsl_nxt;
      lim_r <= lim_nxt;
    end
  end

  // a held backslash only exists inside field text
  a_bsl_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    bsl_r |-> (st_r == ST_QUOTED || st_r == ST_MAYBE_NORMAL))
    else $error("backslash held outside a field");

  // once stopped by the row limit, nothing comes out until restart
  a_limit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && lim_r && !restart) |-> (res.n == 2'd0))
    else $error("result produced past row limit");

  // a skipped CR produces no results
  a_cr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !restart && !cr_r && char_in == CH_CR) |-> (res.n == 2'd0))
    else $error("result produced for skipped CR");

endmodule

// ----- sv/csv_ft_outq.sv -----
// Small result queue: up to two pushes and one pop per cycle.
module csv_ft_outq import csv_ft_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  res_t push,
  input  logic push_en,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output ev_t  out_ev
);

  localparam int AW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  ev_t           mem_r [QDEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [NW-1:0] cnt_r;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push    = push_en ? push.n : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_ev    = mem_r[rd_r];
  assign space     = (cnt_r <= NW'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_r] <= push.ev0;
    if (n_push == 2'd2) mem_r[wr_r + 1'b1] <= push.ev1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(n_push);
      rd_r  <= rd_r + AW'(pop);
      cnt_r <= cnt_r + NW'(n_push) - NW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> (cnt_r <= NW'(QDEPTH - 2)))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(QDEPTH))
    else $error("result queue count out of range");

endmodule

// ----- dv/csv_field_tokenizer_test.sv -----
// Self-checking testbench for the streaming CSV field tokenizer.
`timescale 1ns / 100ps

module csv_field_tokenizer_test;
  import csv_ft_pkg::*;

  localparam int DRAIN_CYCLES   = 12;    // quiet cycles after the last event
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int MAX_REPORTS    = 40;
  localparam logic [7:0] CH_TAB  = 8'd9;
  localparam logic [7:0] CH_SEMI = 8'd59;

  typedef struct packed {
    logic       restart;
    logic [7:0] ch;
  } text_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  csv_field_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer prediction: own copy of parser state and register values.
  // ---------------------------------------------------------------------------
  parse_state_t tok_state = ST_START;
  logic [15:0]  row_cnt   = '0;
  logic [7:0]   col_cnt   = '0;
  logic         cr_seen   = 1'b0;   // one CR swallowed, next byte goes through
  logic         bsl_held  = 1'b0;   // backslash waiting for its follower
  logic         stopped   = 1'b0;   // row limit passed, silent until restart
  logic [7:0]   sep_sh    = CH_COMMA;
  logic [15:0]  limit_sh  = '0;

  ev_t byte_events[$];      // events of the byte being predicted
  ev_t expected_events[$];  // events still owed by the block, oldest first

  task automatic add_event(ev_kind_t k, logic [7:0] c);
    ev_t e;
    e.kind = k;
    e.ch   = c;
    e.row  = row_cnt;
    e.col  = col_cnt;
    e.last = 1'b0;
    byte_events.push_back(e);
  endtask

  // text byte into the field; backslash-n folds into one newline
  task automatic append_text(logic [7:0] c);
    if (bsl_held) begin
      if (c == CH_N) begin
        add_event(EV_APPEND, CH_LF);
        bsl_held = 1'b0;
      end else begin
        add_event(EV_APPEND, CH_BSL);
        if (c != CH_BSL) begin
          add_event(EV_APPEND, c);
          bsl_held = 1'b0;
        end
      end
    end else if (c == CH_BSL) begin
      bsl_held = 1'b1;
    end else begin
      add_event(EV_APPEND, c);
    end
  endtask

  // saturating row / column bookkeeping
  task automatic step_position(logic [7:0] c);
    if (c == CH_LF) begin
      if (row_cnt != '1) row_cnt++;
      col_cnt = '0;
    end else if (col_cnt != '1) begin
      col_cnt++;
    end
  endtask

  task automatic close_field(logic [7:0] c);
    if (bsl_held) begin
      add_event(EV_APPEND, CH_BSL);
      bsl_held = 1'b0;
    end
    add_event(EV_DONE, 8'd0);
    step_position(c);
    tok_state = ST_START;
  endtask

  task automatic tokenize_byte(logic [7:0] x, logic restart);
    logic is_end;
    ev_t  e;
    byte_events.delete();
    if (restart) begin
      tok_state = ST_START;
      row_cnt   = '0;
      col_cnt   = '0;
      cr_seen   = 1'b0;
      bsl_held  = 1'b0;
      stopped   = 1'b0;
    end
    if (stopped) return;
    // first CR of a run is dropped, a second one is treated as data
    if (x == CH_CR && !cr_seen) begin
      cr_seen = 1'b1;
      return;
    end
    cr_seen = 1'b0;
    is_end = (x == sep_sh) || (x == CH_LF);

    case (tok_state)
      ST_QUOTED: begin
        if (x == CH_QUOTE) begin
          append_text(x);
          tok_state = ST_MAYBE_END;
        end else if (x == CH_LF) begin
          close_field(x);
        end else begin
          append_text(x);  // separator is plain text here
        end
      end
      ST_MAYBE_END: begin
        if (x == CH_QUOTE) begin
          append_text(x);
          tok_state = ST_QUOTED;
        end else if (is_end) begin
          close_field(x);
        end else begin
          tok_state = ST_AFTER_QUOTE;
        end
      end
      ST_AFTER_QUOTE: begin
        if (is_end) close_field(x);
      end
      ST_MAYBE_NORMAL, ST_NORMAL: begin
        // quote inside bare text: drop what was built, go quoted
        if (tok_state == ST_MAYBE_NORMAL && x == CH_QUOTE) begin
          bsl_held = 1'b0;
          add_event(EV_DISCARD, 8'd0);
          tok_state = ST_QUOTED;
        end
        if (is_end) close_field(x);
        else append_text(x);
      end
      default: begin
        if (x == CH_QUOTE) begin
          append_text(x);
          tok_state = ST_QUOTED;
        end else if (is_end) begin
          step_position(x);  // empty field: no event
          tok_state = ST_START;
        end else begin
          append_text(x);
          tok_state = ST_MAYBE_NORMAL;
        end
      end
    endcase

    if (limit_sh != '0 && row_cnt > limit_sh) stopped = 1'b1;

    foreach (byte_events[i]) begin
      e = byte_events[i];
      e.last = (i == byte_events.size() - 1);
      expected_events.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts on each accepted byte and
  // checks each accepted event against the oldest expectation.
  // ---------------------------------------------------------------------------
  int fail_count = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    ev_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_SEPARATOR: sep_sh = cfg_data[7:0];
          CFG_ROW_LIMIT: limit_sh = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) tokenize_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("event with nothing expected", {out_tuser, out_tdata[29:0]}, '0);
        end else begin
          want = expected_events.pop_front();
          if (out_tuser != want.kind)
            report_mismatch("event kind", 32'(out_tuser), 32'(want.kind));
          if (out_tdata[7:0] != want.ch)
            report_mismatch("char", 32'(out_tdata[7:0]), 32'(want.ch));
          if (out_tdata[23:8] != want.row)
            report_mismatch("row", 32'(out_tdata[23:8]), 32'(want.row));
          if (out_tdata[31:24] != want.col)
            report_mismatch("column", 32'(out_tdata[31:24]), 32'(want.col));
          if (out_tlast != want.last)
            report_mismatch("last flag", 32'(out_tlast), 32'(want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly no gap, often short gaps, a few long ones, and now
  // and then a calm stretch with no gaps at all.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = 80;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the head of text_bytes, pops it on acceptance.
  // ---------------------------------------------------------------------------
  text_req_t text_bytes[$];
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        text_bytes.delete(0);
        send_gap = pick_gap(send_calm);
      end
      // a request that is not taken stays on the bus unchanged
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (text_bytes.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= text_bytes[0].ch;
          in_tuser  <= text_bytes[0].restart;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure; a hold request blocks it for HOLD_CYCLES
  // so the result queue fills and the input side has to stall.
  // ---------------------------------------------------------------------------
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int recv_gap     = 0;
  int recv_calm    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake restarts the count.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no progress, %0d events outstanding", $time,
                   expected_events.size());
          $display("csv_field_tokenizer_test NOT OK");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int  pushed_count    = 0;
  bit  restart_pending = 1'b0;  // next pushed byte carries restart

  task automatic push_byte(logic [7:0] c);
    text_req_t r;
    r.ch = c;
    r.restart = restart_pending;
    restart_pending = 1'b0;
    text_bytes.push_back(r);
    pushed_count++;
  endtask

  // field text: printable bytes mixed with the characters that matter
  function automatic logic [7:0] text_char(logic [7:0] sep);
    case ($urandom_range(0, 11))
      0, 1:    return CH_BSL;
      2:       return CH_N;
      3:       return CH_QUOTE;
      4:       return sep;
      5:       return CH_CR;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // one CSV record with random content, or a burst of raw noise
  task automatic gen_row(logic [7:0] sep, bit limited);
    int nf;
    int len;
    int mode;
    logic [7:0] c;
    if ($urandom_range(0, limited ? 11 : 39) == 0) restart_pending = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 6);
      repeat (len) push_byte(8'($urandom_range(0, 255)));
      return;
    end
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(0, 5);
      if (mode < 5) begin
        // bare field
        repeat (len) begin
          c = text_char(sep);
          if (c == CH_QUOTE || c == sep || c == CH_LF) c = "x";
          push_byte(c);
        end
        // occasionally a stray quote that turns it into a quoted field
        if ($urandom_range(0, 15) == 0) push_byte(CH_QUOTE);
      end else if (mode < 9) begin
        push_byte(CH_QUOTE);
        repeat (len) begin
          c = text_char(sep);
          if (c == CH_QUOTE) push_byte(CH_QUOTE);  // doubled quote
          push_byte(c);
        end
        push_byte(CH_QUOTE);
        if ($urandom_range(0, 7) == 0) push_byte("j");  // junk after close
      end
      if (f < nf - 1) push_byte(sep);
    end
    if ($urandom_range(0, 2) == 0) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for the block to go idle: all bytes taken, all events seen
  task automatic settle();
    @(negedge clk);
    while (text_bytes.size() > 0 || expected_events.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic [7:0] sep, logic [15:0] limit);
    // upper separator bits are don't-care, so fill them with noise
    write_reg(CFG_SEPARATOR, {8'($urandom_range(0, 255)), sep});
    write_reg(CFG_ROW_LIMIT, limit);
    @(negedge clk);
  endtask

  task automatic run_phase(logic [7:0] sep, logic [15:0] limit, int n_items, bit hold);
    int base;
    set_regs(sep, limit);
    if (hold) hold_request = 1'b1;
    restart_pending = 1'b1;
    base = pushed_count;
    while (pushed_count - base < n_items) gen_row(sep, limit != '0);
    settle();
  endtask

  // directed opener under reset register values (comma, no row limit)
  logic [7:0] directed_bytes[25] = '{
    8'h00, 8'hFF, CH_COMMA,                     // byte extremes, plain field
    CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_COMMA,     // doubled quote, comma kept
    CH_QUOTE, "z", "y", CH_COMMA,               // junk after closing quote
    CH_BSL, CH_BSL, CH_N,                       // double backslash, then \n
    CH_BSL, CH_QUOTE,                           // discard drops held backslash
    CH_BSL, CH_CR, CH_CR, CH_LF,                // CR pair, newline ends quoted
    "a", CH_BSL, CH_CR, CH_LF,                  // held backslash before done
    CH_LF                                       // empty row
  };

  initial begin
    int r;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
    settle();

    run_phase(CH_SEMI, 16'd0, 120, 1'b0);
    run_phase(CH_QUOTE, 16'd0, 80, 1'b0);   // quote doubles as separator
    run_phase(CH_LF, 16'd0, 60, 1'b0);      // newline doubles as separator
    run_phase(8'h00, 16'd3, 100, 1'b0);
    run_phase(8'hFF, 16'd1, 80, 1'b0);
    run_phase(CH_TAB, 16'd0, 120, 1'b1);    // with long receiver hold-off
    run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(2, 10)), 100, 1'b0);

    // column counter saturation: more than 255 fields in one row, with the
    // largest row limit, which a short run never passes
    set_regs(CH_COMMA, 16'hFFFF);
    restart_pending = 1'b1;
    repeat (262) push_byte(CH_COMMA);
    push_byte("a");
    push_byte("b");
    push_byte(CH_COMMA);
    push_byte(CH_LF);
    r = pushed_count;
    while (pushed_count - r < 20) gen_row(CH_COMMA, 1'b0);
    settle();

    run_phase(CH_COMMA, 16'd0, 40, 1'b0);

    if (fail_count == 0) begin
      $display("csv_field_tokenizer_test OK");
    end else begin
      $display("csv_field_tokenizer_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/csv_ft_pkg.sv
sv/csv_ft_step.sv
sv/csv_ft_outq.sv
sv/csv_field_tokenizer.sv
dv/csv_field_tokenizer_test.sv
